/* rtl/sorted_neighbor_table_defines.svh */
// Assertion macros for the sorted neighbour table RTL.
// The macros expect a clock named aclk and an active-low reset named aresetn.
`ifndef SORTED_NEIGHBOR_TABLE_DEFINES_SVH
`define SORTED_NEIGHBOR_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SNT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/snt_pkg.sv */
// Package for the sorted neighbour table: slot entry type, chain link types,
// operation codes and reset constants. No dependencies.
`default_nettype none

package snt_pkg;

    localparam int SNT_DEPTH    = 16;
    localparam int S_DATA_W     = 72;
    localparam int S_USER_W     = 2;
    localparam int M_DATA_W     = 40;
    localparam int TIMEOUT_W    = 31;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd30000;

    // One table slot.
    typedef struct packed {
        logic [15:0]        addr;
        logic [7:0]         grad;
        logic signed [7:0]  rssi;
        logic [31:0]        seen;
    } snt_entry_t;

    localparam snt_entry_t SNT_EMPTY = '{addr: 16'h0000, grad: 8'hFF,
                                         rssi: 8'h80, seen: 32'h0000_0000};

    // Running flags handed from each cell to the next one towards the end.
    typedef struct packed {
        logic match_seen;   // sender found at or before this cell
        logic beat_seen;    // insertion position at or before this cell
        logic lower_seen;   // sender found before its new position
        logic sel_seen;     // indexed slot at or before this cell
    } snt_link_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic       upd;
        logic       rem;
        snt_entry_t item;
    } snt_cmd_t;

    // Table-wide results of the link chain, fed back to every cell.
    typedef struct packed {
        logic any_match;
        logic lower;
    } snt_glob_t;

endpackage

`default_nettype wire

/* rtl/snt_cell.sv */
// One slot of the sorted neighbour table: holds an entry, compares it with
// the sender and takes its own, its neighbour's or the new entry. Uses snt_pkg.
`default_nettype none

module snt_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire snt_pkg::snt_cmd_t  cmd,
    input  wire snt_pkg::snt_glob_t glob,
    input  wire logic               sel,
    input  wire snt_pkg::snt_link_t link_in,
    output snt_pkg::snt_link_t      link_out,
    input  wire snt_pkg::snt_entry_t left_entry,
    input  wire snt_pkg::snt_entry_t right_entry,
    input  wire logic               right_beat,
    output snt_pkg::snt_entry_t     entry,
    output logic                    beat,
    output logic                    match
);
    import snt_pkg::*;

    snt_entry_t entry_reg;
    snt_entry_t entry_next;
    logic       pos_le;
    logic       pos_le_next;
    logic       found_le;

    // Compare the stored entry with the sender and extend the running flags.
    always_comb begin
        match = (entry_reg.addr == cmd.item.addr);
        beat  = (entry_reg.addr == 16'h0000) ||
                (cmd.item.grad < entry_reg.grad) ||
                ((cmd.item.grad == entry_reg.grad) && (cmd.item.rssi > entry_reg.rssi));
        pos_le      = link_in.beat_seen | beat;
        pos_le_next = pos_le | right_beat;
        found_le    = link_in.match_seen | match;
        link_out.match_seen = found_le;
        link_out.beat_seen  = pos_le;
        link_out.lower_seen = link_in.lower_seen | (match & ~pos_le);
        link_out.sel_seen   = link_in.sel_seen | sel;
    end

    // Choose the next contents: keep, shift from a neighbour or take the sender.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.upd) begin
            if (glob.any_match && glob.lower) begin
                // The sender moves towards the end: the slots between close up.
                if (found_le && !pos_le_next) begin
                    entry_next = right_entry;
                end else if (!pos_le && pos_le_next) begin
                    entry_next = cmd.item;
                end
            end else begin
                // New sender, or a known one that moves towards the front or stays in place.
                if (pos_le && !link_in.beat_seen) begin
                    entry_next = cmd.item;
                end else if (link_in.beat_seen && !link_in.match_seen) begin
                    entry_next = left_entry;
                end
            end
        end else if (cmd.rem && (link_in.sel_seen || sel)) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= SNT_EMPTY;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* rtl/sorted_neighbor_table.sv */
// Top level of the sorted neighbour table: item capture, a row of snt_cell
// slots, result register and configuration. Uses snt_pkg and snt_cell.
//
// Usage:
// Items arrive on the s_ channel (s_tvalid, s_tready, s_tdata, s_tuser with
// the opcode in s_tuser) and each one gives exactly one result item on the
// m_ channel. An update inserts, moves or refreshes a neighbour in a table
// kept best first; a remove deletes the entry at slot_index and closes the
// gap; a query returns the entry at slot_index with its expiry flag.
// The item is captured at acceptance, and the whole row of cells compares and
// shifts in the following cycle, at whose end the result register is loaded.
// No new item is accepted during that execution cycle, in which every cell
// settles through the link chain running along the row.
// The expiry timeout is written through cfg_wen and cfg_wdata between items.
// Reset empties every slot at once, loads the timeout with 30000 and holds
// s_tready low.
// While the receiver holds m_tready low the result register keeps its item
// and no new item is accepted until it has been taken.
`default_nettype none
`include "sorted_neighbor_table_defines.svh"

module sorted_neighbor_table #(
    parameter int TABLE_DEPTH = snt_pkg::SNT_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // nbr_addr[15:0], nbr_grad[23:16], nbr_rssi[31:24],
    // timestamp[63:32], slot_index[67:64], zero padding above
    input  wire logic [snt_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  wire logic [snt_pkg::S_USER_W-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[0], entry_valid[1], entry_addr[17:2], entry_gradient[25:18],
    // entry_rssi[33:26], entry_expired[34], zero padding above
    output logic [snt_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                           cfg_wen,
    input  wire logic [snt_pkg::TIMEOUT_W-1:0]  cfg_wdata
);
    import snt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [1:0]             op_reg;
    snt_entry_t             item_reg;
    logic [3:0]             idx_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    snt_cmd_t               cmd;
    snt_glob_t              glob;
    snt_link_t              link [TABLE_DEPTH+1];
    snt_entry_t             entry_q [TABLE_DEPTH];
    snt_entry_t             left_q [TABLE_DEPTH];
    snt_entry_t             right_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] rbeat;
    logic [TABLE_DEPTH-1:0] beat_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] sel_vec;
    logic [TABLE_DEPTH-1:0] trail_bad;

    logic [$bits(snt_entry_t)-1:0] sel_bits;
    snt_entry_t             sel_entry;

    logic                   res_status;
    logic                   res_valid;
    logic [15:0]            res_addr;
    logic [7:0]             res_grad;
    logic [7:0]             res_rssi;
    logic                   res_chk;

    logic                   m_tvalid_reg;
    logic                   status_reg;
    logic                   valid_reg;
    logic [15:0]            addr_reg;
    logic [7:0]             grad_reg;
    logic [7:0]             rssi_reg;
    logic [31:0]            age_reg;
    logic                   chk_reg;
    logic                   expired;

    // Handshake: take an item only out of reset, when idle and the result
    // register frees up.
    assign s_tready = aresetn && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);

    // Sequencer: idle until an item is captured, then the execution state, then idle.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg        <= s_tuser[1:0];
            item_reg.addr <= s_tdata[15:0];
            item_reg.grad <= s_tdata[23:16];
            item_reg.rssi <= s_tdata[31:24];
            item_reg.seen <= s_tdata[63:32];
            idx_reg       <= s_tdata[67:64];
        end
    end

    // Expiry timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wen) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Command to the row of cells; the globals come from the end of the chain.
    always_comb begin
        cmd.upd  = (state_reg == ST_EXEC) && (op_reg == OP_UPDATE) &&
                   (item_reg.addr != 16'h0000);
        cmd.rem  = (state_reg == ST_EXEC) && (op_reg == OP_REMOVE);
        cmd.item = item_reg;
        glob.any_match = link[TABLE_DEPTH].match_seen;
        glob.lower     = link[TABLE_DEPTH].lower_seen;
    end

    assign link[0] = '0;

    // The row of cells, each wired to its two neighbours.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_left_edge
            assign left_q[g] = SNT_EMPTY;
        end else begin : g_left_inner
            assign left_q[g] = entry_q[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_right_edge
            assign right_q[g] = SNT_EMPTY;
            assign rbeat[g]   = 1'b1;
        end else begin : g_right_inner
            assign right_q[g] = entry_q[g+1];
            assign rbeat[g]   = beat_vec[g+1];
        end

        assign sel_vec[g]   = (32'(idx_reg) == g);
        assign trail_bad[g] = (entry_q[g].addr == 16'h0000) &&
                              (right_q[g].addr != 16'h0000);

        snt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .glob        (glob),
            .sel         (sel_vec[g]),
            .link_in     (link[g]),
            .link_out    (link[g+1]),
            .left_entry  (left_q[g]),
            .right_entry (right_q[g]),
            .right_beat  (rbeat[g]),
            .entry       (entry_q[g]),
            .beat        (beat_vec[g]),
            .match       (match_vec[g])
        );
    end

    // Indexed slot, picked from the row by its select line.
    always_comb begin
        sel_bits = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (sel_vec[i]) begin
                sel_bits = sel_bits | entry_q[i];
            end
        end
        sel_entry = snt_entry_t'(sel_bits);
    end

    // Result fields for each operation.
    always_comb begin
        res_status = 1'b1;
        res_valid  = 1'b0;
        res_addr   = 16'h0000;
        res_grad   = 8'h00;
        res_rssi   = 8'h00;
        res_chk    = 1'b0;
        case (op_reg)
            OP_UPDATE: begin
                res_status = !((item_reg.addr != 16'h0000) &&
                               (glob.any_match || link[TABLE_DEPTH].beat_seen));
            end
            OP_REMOVE: begin
                res_status = (sel_entry.addr == 16'h0000);
                res_addr   = sel_entry.addr;
            end
            OP_QUERY: begin
                if (sel_entry.addr != 16'h0000) begin
                    res_status = 1'b0;
                    res_valid  = 1'b1;
                    res_addr   = sel_entry.addr;
                    res_grad   = sel_entry.grad;
                    res_rssi   = sel_entry.rssi;
                    res_chk    = 1'b1;
                end
            end
            default: begin
                res_status = 1'b1;
            end
        endcase
    end

    // Result register; the age is stored and compared on the way out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_EXEC) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            status_reg <= res_status;
            valid_reg  <= res_valid;
            addr_reg   <= res_addr;
            grad_reg   <= res_grad;
            rssi_reg   <= res_rssi;
            age_reg    <= item_reg.seen - sel_entry.seen;
            chk_reg    <= res_chk;
        end
    end

    assign expired  = chk_reg && (age_reg > {1'b0, timeout_reg});
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, expired, rssi_reg, grad_reg, addr_reg, valid_reg, status_reg};

    // Checks on the sequencer and on the table ordering.
    `SNT_ASSERT_IMP(a_exec_out_free, state_reg == ST_EXEC, !m_tvalid_reg, "result register busy during execution")
    `SNT_ASSERT_NXT(a_exec_result, state_reg == ST_EXEC, m_tvalid_reg, "execution gave no result item")
    `SNT_ASSERT_IMP(a_unique_addr, (state_reg == ST_EXEC) && (item_reg.addr != 16'h0000), $onehot0(match_vec), "address held in more than one slot")
    `SNT_ASSERT_IMP(a_empty_trail, 1'b1, trail_bad == '0, "occupied slot follows an empty slot")

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the sorted neighbour table (sorted_neighbor_table).
// Depends on snt_pkg and the block's RTL; it keeps its own copy of the table to
// predict every result item and checks each one field by field.
`timescale 1ns / 100ps

module tb;
    import snt_pkg::*;

    localparam int          SLOTS           = SNT_DEPTH;
    localparam logic [1:0]  OP_SPARE        = 2'd3;
    localparam logic [15:0] ADDR_UNASSIGNED = 16'h0000;
    localparam int          RUN_LIMIT       = 200000;
    localparam int          POOL_SIZE       = 24;

    // Input item fields, highest field first, as packed into s_tdata.
    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] ts;
        logic [7:0]  rssi;
        logic [7:0]  grad;
        logic [15:0] addr;
    } nbr_req_t;

    // Result item fields, highest field first, as packed into m_tdata.
    typedef struct packed {
        logic        expired;
        logic [7:0]  rssi;
        logic [7:0]  grad;
        logic [15:0] addr;
        logic        valid;
        logic        status;
    } nbr_reply_t;

    typedef struct {
        logic [15:0] addr;
        logic [7:0]  grad;
        byte         rssi;
        logic [31:0] seen;
    } nbr_slot_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic [S_USER_W-1:0]     s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    cfg_wen   = 1'b0;
    logic [TIMEOUT_W-1:0]    cfg_wdata = '0;

    // Predicted table and timeout, and the results still awaited from the block.
    nbr_slot_t               nbr_table [SLOTS];
    logic [TIMEOUT_W-1:0]    expiry_ms = TIMEOUT_RESET;
    nbr_reply_t              awaited_replies [$];

    int                      mismatch_count = 0;
    int                      cycle_count    = 0;
    int                      burst_left     = 0;
    int                      gap_max        = 0;
    int                      ready_mode     = 0;
    int                      hold_req       = 0;
    int                      hold_left      = 0;
    logic [7:0]              stall_pat      = 8'b1101_0110;
    logic [31:0]             now_ms         = 32'd0;
    logic [15:0]             addr_pool [POOL_SIZE];

    sorted_neighbor_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Applies one item to the predicted table and returns the result it gives.
    function automatic nbr_reply_t nbr_table_apply(logic [1:0] op, nbr_req_t r);
        nbr_reply_t  reply;
        int          found;
        int          pos;
        int          i;
        byte         rin;
        logic [15:0] gone;
        logic [31:0] age;
        reply = '0;
        reply.status = 1'b1;
        rin = r.rssi;
        case (op)
            OP_UPDATE: begin
                if (r.addr == ADDR_UNASSIGNED)
                    return reply;
                found = -1;
                pos = SLOTS;
                for (i = 0; i < SLOTS; i++)
                    if (found < 0 && nbr_table[i].addr == r.addr)
                        found = i;
                // The new position is the first empty slot or the first entry beaten.
                for (i = 0; i < SLOTS; i++)
                    if (pos == SLOTS && (nbr_table[i].addr == ADDR_UNASSIGNED ||
                        r.grad < nbr_table[i].grad ||
                        (r.grad == nbr_table[i].grad && rin > nbr_table[i].rssi)))
                        pos = i;
                if (found < 0) begin
                    // A newcomer worse than every entry of a full table is turned away.
                    if (pos >= SLOTS)
                        return reply;
                    for (i = SLOTS - 1; i > pos; i--)
                        nbr_table[i] = nbr_table[i - 1];
                end else if (found > pos) begin
                    for (i = found; i > pos; i--)
                        nbr_table[i] = nbr_table[i - 1];
                end else if (found < pos) begin
                    for (i = found; i < pos && i + 1 < SLOTS; i++)
                        nbr_table[i] = nbr_table[i + 1];
                    pos--;
                end
                nbr_table[pos] = '{addr: r.addr, grad: r.grad, rssi: rin, seen: r.ts};
                reply.status = 1'b0;
            end
            OP_REMOVE: begin
                gone = nbr_table[r.idx].addr;
                for (i = int'(r.idx); i < SLOTS - 1; i++)
                    nbr_table[i] = nbr_table[i + 1];
                nbr_table[SLOTS - 1] = '{addr: ADDR_UNASSIGNED, grad: 8'hFF,
                                         rssi: byte'(-128), seen: 32'd0};
                reply.status = (gone == ADDR_UNASSIGNED);
                reply.addr = gone;
            end
            OP_QUERY: begin
                if (nbr_table[r.idx].addr != ADDR_UNASSIGNED) begin
                    age = r.ts - nbr_table[r.idx].seen;
                    reply.status = 1'b0;
                    reply.valid = 1'b1;
                    reply.addr = nbr_table[r.idx].addr;
                    reply.grad = nbr_table[r.idx].grad;
                    reply.rssi = nbr_table[r.idx].rssi;
                    reply.expired = (age > {1'b0, expiry_ms});
                end
            end
            default: begin
                // The spare opcode leaves the table alone and is refused.
            end
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Offers one item in bursts with random gaps, then records its prediction.
    task automatic send_item(logic [1:0] op, nbr_req_t r);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0)
                gap = $urandom_range(0, gap_max);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - $bits(nbr_req_t)){1'b0}}, r};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        awaited_replies.push_back(nbr_table_apply(op, r));
    endtask

    task automatic send_op(logic [1:0] op, logic [15:0] addr, logic [7:0] grad,
                           logic [7:0] rssi, logic [31:0] ts, logic [3:0] idx);
        nbr_req_t r;
        r = '{idx: idx, ts: ts, rssi: rssi, grad: grad, addr: addr};
        send_item(op, r);
    endtask

    // Lets the block drain so that the timeout may be rewritten safely.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_expiry_timeout(logic [TIMEOUT_W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        expiry_ms = value;
    endtask

    // Mostly updates from a small set of neighbours, so the table fills up
    // and newcomers get turned away; the rest is removes, queries and noise.
    task automatic make_random_item(output logic [1:0] op, output nbr_req_t r);
        int pick;
        int used;
        int i;
        used = 0;
        for (i = 0; i < SLOTS; i++)
            if (nbr_table[i].addr != ADDR_UNASSIGNED)
                used++;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            op = OP_UPDATE;
        else if (pick < 72)
            op = OP_REMOVE;
        else if (pick < 96)
            op = OP_QUERY;
        else
            op = OP_SPARE;
        if ($urandom_range(0, 9) == 0)
            now_ms = $urandom();
        else
            now_ms = now_ms + $urandom_range(0, 8000);
        pick = $urandom_range(0, 99);
        if (pick < 75)
            r.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 95)
            r.addr = 16'($urandom());
        else
            r.addr = ADDR_UNASSIGNED;
        r.grad = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 40)) :
                                              8'($urandom_range(0, 255));
        r.rssi = 8'($urandom());
        r.ts = now_ms;
        if (used > 0 && $urandom_range(0, 9) < 6)
            r.idx = 4'($urandom_range(0, used - 1));
        else
            r.idx = 4'($urandom_range(0, SLOTS - 1));
    endtask

    // Hand-picked items covering every operation and the corner cases.
    task automatic test_directed_ops();
        gap_max = 3;
        ready_mode = 1;
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd1000,       4'd0);
        send_op(OP_UPDATE, 16'h0000, 8'h05, 8'h10, 32'd1000,       4'd0);
        send_op(OP_UPDATE, 16'hFFFF, 8'h00, 8'h80, 32'hFFFF_FFF0,  4'd0);
        send_op(OP_UPDATE, 16'h0001, 8'hFF, 8'h7F, 32'd0,          4'd0);
        send_op(OP_UPDATE, 16'h8000, 8'hFF, 8'h80, 32'd50,         4'd0);
        // A known sender that now beats the head moves up.
        send_op(OP_UPDATE, 16'h0001, 8'h00, 8'h7F, 32'd100,        4'd0);
        send_op(OP_UPDATE, 16'hFFFF, 8'h00, 8'h80, 32'd200,        4'd0);
        // Same slot, better gradient: refreshed in place.
        send_op(OP_UPDATE, 16'h8000, 8'h07, 8'h00, 32'd300,        4'd0);
        send_op(OP_UPDATE, 16'h1234, 8'h07, 8'h00, 32'd400,        4'd0);
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd30200,      4'd1);
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd30201,      4'd1);
        // Age wraps below the time it was last heard.
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd50,         4'd0);
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd400,        4'd3);
        send_op(OP_QUERY,  16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,  4'd15);
        send_op(OP_REMOVE, 16'h0000, 8'h00, 8'h00, 32'd0,          4'd15);
        send_op(OP_REMOVE, 16'h0000, 8'h00, 8'h00, 32'd0,          4'd1);
        send_op(OP_SPARE,  16'hA5A5, 8'h5A, 8'hC3, 32'h5A5A_A5A5,  4'd2);
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd500,        4'd1);
        send_op(OP_QUERY,  16'h0000, 8'h00, 8'h00, 32'd500,        4'd2);
    endtask

    // The expiry test at the smallest and the largest timeout.
    task automatic test_timeout_extremes();
        logic [31:0] seen;
        quiesce();
        write_expiry_timeout('0);
        seen = nbr_table[0].seen;
        send_op(OP_QUERY, 16'h0000, 8'h00, 8'h00, seen,              4'd0);
        send_op(OP_QUERY, 16'h0000, 8'h00, 8'h00, seen + 32'd1,      4'd0);
        quiesce();
        write_expiry_timeout({TIMEOUT_W{1'b1}});
        send_op(OP_QUERY, 16'h0000, 8'h00, 8'h00, seen + 32'h7FFF_FFFF, 4'd0);
        send_op(OP_QUERY, 16'h0000, 8'h00, 8'h00, seen + 32'h8000_0000, 4'd0);
    endtask

    task automatic run_random_traffic(int count, logic [TIMEOUT_W-1:0] timeout,
                                      int gaps, int stall_mode);
        logic [1:0] op;
        nbr_req_t   r;
        quiesce();
        write_expiry_timeout(timeout);
        gap_max = gaps;
        ready_mode = stall_mode;
        repeat (count) begin
            make_random_item(op, r);
            send_item(op, r);
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure(int count);
        logic [1:0] op;
        nbr_req_t   r;
        quiesce();
        gap_max = 0;
        ready_mode = 0;
        hold_req = 400;
        repeat (count) begin
            make_random_item(op, r);
            send_item(op, r);
        end
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall mode.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= stall_pat[0];
            endcase
        end
    end

    // Each result item is checked against the oldest prediction.
    always @(posedge aclk) begin
        nbr_reply_t got;
        nbr_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(nbr_reply_t)-1:0];
            if (awaited_replies.size() == 0) begin
                report_mismatch("result item with no item outstanding");
            end else begin
                want = awaited_replies.pop_front();
                check_field("status",         16'(got.status),  16'(want.status));
                check_field("entry_valid",    16'(got.valid),   16'(want.valid));
                check_field("entry_addr",     got.addr,         want.addr);
                check_field("entry_gradient", 16'(got.grad),    16'(want.grad));
                check_field("entry_rssi",     16'(got.rssi),    16'(want.rssi));
                check_field("entry_expired",  16'(got.expired), 16'(want.expired));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++)
            nbr_table[i] = '{addr: ADDR_UNASSIGNED, grad: 8'hFF, rssi: byte'(-128),
                             seen: 32'd0};
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = 16'($urandom_range(1, 16'hFFFF));
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_directed_ops();
        test_timeout_extremes();
        run_random_traffic(120, TIMEOUT_RESET, 0, 0);
        run_random_traffic(120, '0, 6, 1);
        run_random_traffic(120, {TIMEOUT_W{1'b1}}, 3, 2);
        run_random_traffic(100, TIMEOUT_W'($urandom_range(1, 20000)), 10, 1);
        test_backpressure(30);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/snt_pkg.sv
rtl/snt_cell.sv
rtl/sorted_neighbor_table.sv
dv/tb.sv
